// ----- hw/rtl/pfsa_pkg.sv -----
// Package for the page frame stack allocator: sizes, operation codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none
package pfsa_pkg;
   localparam int STACK_DEPTH = 65536;
   localparam int PAGE_BYTES  = 4096;
   localparam int IDX_W   = $clog2(STACK_DEPTH);
   localparam int CNT_W   = IDX_W + 1;
   localparam logic [63:0] PMASK = 64'(PAGE_BYTES - 1);
   localparam logic [63:0] MAX64 = '1;
   localparam logic [63:0] LIMIT_RESET = 64'h0000_0000_C000_0000;
   localparam logic [63:0] GUARD_RESET = 64'd16 << 20;

   typedef enum logic [2:0] {
      OP_CLEAR = 3'd0, OP_FREE = 3'd1, OP_ALLOC = 3'd2,
      OP_RESERVE = 3'd3, OP_ADD = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CSR_KSTART = 2'd0, CSR_KEND = 2'd1, CSR_LIMIT = 2'd2, CSR_GUARD = 2'd3
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_POP, ST_RS_START, ST_RS_SCAN, ST_RS_MOVE,
      ST_AR_CLIP, ST_AR_SETUP, ST_AR_GUARD, ST_AR_LOOP, ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic push_addr;
      logic pop;
      logic rs_init;
      logic scan_init;
      logic scan_step;
      logic rd_top;
      logic rs_move;
      logic ar_clip;
      logic ar_setup;
      logic ar_guard;
      logic ar_step;
      logic rsp;
   } cmd_type;

   typedef struct packed {
      logic scan_end;
      logic found;
      logic rs_last;
      logic ar_skip;
      logic ar_nopages;
      logic ar_end;
   } sts_type;
endpackage
`default_nettype wire

// ----- hw/rtl/pfsa_ctrl.sv -----
// Controller state machine of the page frame stack allocator.
// Depends on pfsa_pkg; drives the datapath by command struct.
`default_nettype none
module pfsa_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [2:0]       op,
   input  wire pfsa_pkg::sts_type sts,
   output logic                  busy,
   output pfsa_pkg::cmd_type     cmd
);
   pfsa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pfsa_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != pfsa_pkg::ST_IDLE);
      unique case (state_ff)
         pfsa_pkg::ST_IDLE: begin
            if (start) begin
               unique case (op)
                  pfsa_pkg::OP_CLEAR: begin
                     cmd.clear = 1'b1; state_in = pfsa_pkg::ST_DONE;
                  end
                  pfsa_pkg::OP_FREE: begin
                     cmd.push_addr = 1'b1; state_in = pfsa_pkg::ST_DONE;
                  end
                  pfsa_pkg::OP_ALLOC: begin
                     cmd.pop = 1'b1; state_in = pfsa_pkg::ST_POP;
                  end
                  pfsa_pkg::OP_RESERVE: begin
                     cmd.rs_init = 1'b1; state_in = pfsa_pkg::ST_RS_START;
                  end
                  pfsa_pkg::OP_ADD: begin
                     cmd.ar_clip = 1'b1; state_in = pfsa_pkg::ST_AR_CLIP;
                  end
                  default: state_in = pfsa_pkg::ST_DONE;
               endcase
            end
         end
         pfsa_pkg::ST_POP: state_in = pfsa_pkg::ST_DONE;
         pfsa_pkg::ST_RS_START: begin
            cmd.scan_init = 1'b1; state_in = pfsa_pkg::ST_RS_SCAN;
         end
         pfsa_pkg::ST_RS_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_end) begin
               cmd.scan_step = 1'b0;
               if (sts.found) begin cmd.rd_top = 1'b1; state_in = pfsa_pkg::ST_RS_MOVE; end
               else state_in = pfsa_pkg::ST_DONE;
            end
         end
         pfsa_pkg::ST_RS_MOVE: begin
            cmd.rs_move = 1'b1;
            state_in = sts.rs_last ? pfsa_pkg::ST_DONE : pfsa_pkg::ST_RS_START;
         end
         pfsa_pkg::ST_AR_CLIP: begin
            if (sts.ar_skip) state_in = pfsa_pkg::ST_DONE;
            else begin cmd.ar_setup = 1'b1; state_in = pfsa_pkg::ST_AR_SETUP; end
         end
         pfsa_pkg::ST_AR_SETUP: begin
            if (sts.ar_nopages) state_in = pfsa_pkg::ST_DONE;
            else begin cmd.ar_guard = 1'b1; state_in = pfsa_pkg::ST_AR_GUARD; end
         end
         pfsa_pkg::ST_AR_GUARD: state_in = pfsa_pkg::ST_AR_LOOP;
         pfsa_pkg::ST_AR_LOOP: begin
            if (sts.ar_end) state_in = pfsa_pkg::ST_DONE;
            else cmd.ar_step = 1'b1;
         end
         pfsa_pkg::ST_DONE: begin cmd.rsp = 1'b1; state_in = pfsa_pkg::ST_IDLE; end
         default: state_in = pfsa_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ----- hw/rtl/pfsa_dp.sv -----
// Datapath of the page frame stack allocator: stack memory, pointers,
// range walkers and result registers. Depends on pfsa_pkg.
`default_nettype none
module pfsa_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire logic [63:0]         address,
   input  wire logic [63:0]         length,
   input  wire logic [31:0]         region_type,
   input  wire logic                csr_write,
   input  wire logic [1:0]          csr_index,
   input  wire logic [63:0]         csr_data,
   input  wire pfsa_pkg::cmd_type   cmd,
   output pfsa_pkg::sts_type        sts,
   output logic                     rsp_valid,
   output logic [63:0]              rsp_frame_address,
   output logic [16:0]              rsp_free_pages,
   output logic [63:0]              rsp_total_memory
);
   localparam int IW = pfsa_pkg::IDX_W;
   localparam int CW = pfsa_pkg::CNT_W;
   localparam logic [CW-1:0] DEPTH = CW'(pfsa_pkg::STACK_DEPTH);
   localparam logic [63:0] PB = 64'(pfsa_pkg::PAGE_BYTES);

   logic [63:0] mem [pfsa_pkg::STACK_DEPTH];
   logic [63:0] rd_ff;
   logic        we;
   logic [IW-1:0] wa, ra;
   logic [63:0] wd;

   logic [CW-1:0] top_ff;
   logic [63:0] total_ff, kstart_ff, kend_ff, limit_ff, guard_ff;
   logic [63:0] addr_ff, len_ff, a_ff, end_ff, stop_ff, best_ff, popped_ff;
   logic [31:0] type_ff;
   logic        to_top_ff, found_ff, valid_ff, pop_rd_ff;
   logic [CW-1:0] scan_ff, where_ff;
   logic        scan_rd_ff;
   logic [CW-1:0] scan_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kstart_ff <= '0; kend_ff <= '0;
         limit_ff <= pfsa_pkg::LIMIT_RESET; guard_ff <= pfsa_pkg::GUARD_RESET;
      end else if (csr_write) begin
         unique case (pfsa_pkg::csr_type'(csr_index))
            pfsa_pkg::CSR_KSTART: kstart_ff <= csr_data;
            pfsa_pkg::CSR_KEND:   kend_ff <= csr_data;
            pfsa_pkg::CSR_LIMIT:  limit_ff <= csr_data;
            pfsa_pkg::CSR_GUARD:  guard_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // memory port selection
   logic in_kern;
   logic [CW-1:0] top_m1;
   assign top_m1 = top_ff - CW'(1);
   assign in_kern = (a_ff >= kstart_ff) && (a_ff < kend_ff);

   always_comb begin
      we = 1'b0; wa = top_ff[IW-1:0]; wd = address; ra = top_m1[IW-1:0];
      if (cmd.push_addr) we = (address != '0) && (top_ff < DEPTH);
      if (cmd.ar_step) begin
         we = !in_kern && (a_ff != '0) && (a_ff < stop_ff) && (top_ff < DEPTH);
         wd = a_ff;
      end
      if (cmd.rs_move) begin we = 1'b1; wa = where_ff[IW-1:0]; wd = rd_ff; end
      if (cmd.scan_step || cmd.scan_init) ra = scan_ff[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   // reserve scan: one entry a cycle, compared in the cycle after its read
   logic [CW-1:0] scan_nx;
   logic          hit;
   assign scan_nx = scan_ff + CW'(1);
   assign hit = scan_rd_ff && ((rd_ff & pfsa_pkg::PMASK) == '0) && (rd_ff >= a_ff)
                && (to_top_ff || rd_ff < end_ff) && (!found_ff || rd_ff < best_ff);

   // region arithmetic
   logic [63:0] room, clip_len, start_pg, span, nxt_a, kend_up;
   assign room = limit_ff - addr_ff;
   assign clip_len = (len_ff > room) ? room : len_ff;
   assign start_pg = (addr_ff + pfsa_pkg::PMASK) & ~pfsa_pkg::PMASK;
   assign span = stop_ff - a_ff;
   assign kend_up = (kend_ff + pfsa_pkg::PMASK) & ~pfsa_pkg::PMASK;
   assign nxt_a = a_ff + PB;

   logic ar_done;
   always_comb begin
      ar_done = (a_ff >= stop_ff) || (top_ff >= DEPTH);
      if (!ar_done && in_kern && kend_ff > pfsa_pkg::MAX64 - pfsa_pkg::PMASK) ar_done = 1'b1;
   end

   always_comb begin
      sts.scan_end   = !scan_rd_ff && !(scan_ff < top_ff) && (scan_idx_ff == scan_ff);
      sts.found      = found_ff;
      sts.rs_last    = best_ff > pfsa_pkg::MAX64 - PB;
      sts.ar_skip    = (type_ff != 32'd1) || (addr_ff >= limit_ff);
      sts.ar_nopages = (addr_ff > pfsa_pkg::MAX64 - pfsa_pkg::PMASK) || (stop_ff <= a_ff);
      sts.ar_end     = ar_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0; total_ff <= '0; valid_ff <= 1'b0;
         scan_rd_ff <= 1'b0; found_ff <= 1'b0; pop_rd_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.rsp;
         pop_rd_ff <= cmd.pop && (top_ff != '0);
         if (start && !busy) begin
            addr_ff <= address; len_ff <= length; type_ff <= region_type;
            popped_ff <= '0;
         end
         if (pop_rd_ff) popped_ff <= rd_ff;
         if (cmd.clear) begin top_ff <= '0; total_ff <= '0; end
         if (cmd.push_addr && address != '0 && top_ff < DEPTH) top_ff <= top_ff + CW'(1);
         if (cmd.pop && top_ff != '0) top_ff <= top_m1;
         if (cmd.rs_init) begin
            a_ff <= address & ~pfsa_pkg::PMASK;
            to_top_ff <= length > pfsa_pkg::MAX64 - address;
            end_ff <= address + length;
         end
         scan_rd_ff <= cmd.scan_step && (scan_ff < top_ff);
         if (cmd.scan_init) begin
            found_ff <= 1'b0; best_ff <= '0; where_ff <= '0;
            scan_ff <= '0; scan_idx_ff <= '1;
         end else if (cmd.scan_step) begin
            scan_idx_ff <= scan_ff;
            if (scan_ff < top_ff) scan_ff <= scan_nx;
            if (hit) begin found_ff <= 1'b1; best_ff <= rd_ff; where_ff <= scan_idx_ff; end
         end
         if (cmd.rd_top) top_ff <= top_m1;
         if (cmd.rs_move) a_ff <= best_ff + PB;
         if (cmd.ar_clip) ;
         if (cmd.ar_setup) begin
            total_ff <= total_ff + clip_len;
            len_ff <= clip_len;
            a_ff <= start_pg;
            stop_ff <= (addr_ff + clip_len) & ~pfsa_pkg::PMASK;
         end
         if (cmd.ar_guard) begin
            if (span > guard_ff && span - guard_ff > guard_ff) stop_ff <= stop_ff - guard_ff;
         end
         if (cmd.ar_step) begin
            if (in_kern) a_ff <= kend_up;
            else begin
               if (a_ff != '0) top_ff <= top_ff + CW'(1);
               if (a_ff > pfsa_pkg::MAX64 - PB) stop_ff <= '0;
               a_ff <= nxt_a;
            end
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_frame_address = popped_ff;
   assign rsp_free_pages = 17'(top_ff);
   assign rsp_total_memory = total_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/page_frame_stack_allocator_top.sv -----
// Top level of the page frame stack allocator.
// Depends on pfsa_pkg, pfsa_ctrl and pfsa_dp.
//
// Usage: present an item on req_* with start high; it is accepted when
// busy is low. One result per item appears on rsp_* for one cycle with
// rsp_valid high; the receiver cannot stall it.
// Alloc reads the stack in ST_POP; clear and free go straight to ST_DONE.
// Reserve rescans the stack once per removed page. add_region pushes one
// page a cycle, save for steps over the kernel range, after ST_AR_CLIP,
// ST_AR_SETUP and ST_AR_GUARD, as the stack memory has one write port.
// Configuration writes on csr_* are to be made only while idle; the block
// does not enforce it. Reset empties the stack, zeroes the total and
// restores register defaults; stack contents need no clearing pass.
`default_nettype none
module page_frame_stack_allocator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_operation,
   input  wire logic [63:0] req_address,
   input  wire logic [63:0] req_length,
   input  wire logic [31:0] req_region_type,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data,
   output logic             rsp_valid,
   output logic [63:0]      rsp_frame_address,
   output logic [16:0]      rsp_free_pages,
   output logic [63:0]      rsp_total_memory
);
   pfsa_pkg::cmd_type cmd;
   pfsa_pkg::sts_type sts;

   pfsa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .op(req_operation),
      .sts(sts), .busy(busy), .cmd(cmd)
   );

   pfsa_dp u_dp (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .address(req_address), .length(req_length), .region_type(req_region_type),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .cmd(cmd), .sts(sts), .rsp_valid(rsp_valid),
      .rsp_frame_address(rsp_frame_address), .rsp_free_pages(rsp_free_pages),
      .rsp_total_memory(rsp_total_memory)
   );
endmodule
`default_nettype wire
